// ===== rtl/blpf_pkg.sv =====
// Shared types and constants of the paged framebuffer line engine.
// No dependencies; imported by the controller, the datapath and the top level.
package blpf_pkg;

   localparam int DEF_MAX_WIDTH  = 128;
   localparam int DEF_MAX_HEIGHT = 64;

   localparam logic [1:0] OP_DRAW  = 2'd0;
   localparam logic [1:0] OP_CLEAR = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_NOP   = 2'd3;

   localparam logic CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [7:0] SCREEN_WIDTH_RESET  = 8'd128;
   localparam logic [6:0] SCREEN_HEIGHT_RESET = 7'd64;

   typedef struct packed {
      logic load;
      logic cnt_clear;
      logic cnt_inc;
      logic wipe_write;
      logic fill_write;
      logic pix_read;
      logic pix_write;
      logic finish;
      logic clip;
      logic read_result;
   } blpf_cmd_type;

   typedef struct packed {
      logic on_screen;
      logic at_end;
      logic wipe_last;
      logic fill_done;
   } blpf_status_type;

endpackage

// ===== rtl/blpf_ctrl.sv =====
// Sequencer of the line engine: power-up wipe, draw, clear and read sequences.
// Depends on blpf_pkg; drives blpf_datapath through command and status structs.
module blpf_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [1:0]                req_op,
   input  blpf_pkg::blpf_status_type status,
   output blpf_pkg::blpf_cmd_type    cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import blpf_pkg::*;

   localparam logic [2:0] ST_WIPE       = 3'd0;
   localparam logic [2:0] ST_IDLE       = 3'd1;
   localparam logic [2:0] ST_LINE_CHECK = 3'd2;
   localparam logic [2:0] ST_LINE_WRITE = 3'd3;
   localparam logic [2:0] ST_FILL       = 3'd4;
   localparam logic [2:0] ST_READ       = 3'd5;
   localparam logic [2:0] ST_READ_WAIT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_WIPE: begin
            cmd.wipe_write = 1'b1;
            if (status.wipe_last) begin
               cmd.cnt_clear = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.cnt_inc = 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load      = 1'b1;
               cmd.cnt_clear = 1'b1;
               unique case (req_op)
                  OP_DRAW:  state_in = ST_LINE_CHECK;
                  OP_CLEAR: state_in = ST_FILL;
                  OP_READ:  state_in = ST_READ;
                  OP_NOP:   cmd.finish = 1'b1;
                  default:  cmd.finish = 1'b1;
               endcase
            end
         end
         ST_LINE_CHECK: begin
            if (status.on_screen) begin
               cmd.pix_read = 1'b1;
               state_in     = ST_LINE_WRITE;
            end else begin
               cmd.finish = 1'b1;
               cmd.clip   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_LINE_WRITE: begin
            cmd.pix_write = 1'b1;
            if (status.at_end) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               state_in = ST_LINE_CHECK;
            end
         end
         ST_FILL: begin
            if (status.fill_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.fill_write = 1'b1;
               cmd.cnt_inc    = 1'b1;
            end
         end
         ST_READ: begin
            state_in = ST_READ_WAIT;
         end
         ST_READ_WAIT: begin
            cmd.finish      = 1'b1;
            cmd.read_result = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= cmd.finish;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/blpf_datapath.sv =====
// Datapath of the line engine: Bresenham registers, byte address, pixel store.
// Depends on blpf_pkg; sequenced by blpf_ctrl.
module blpf_datapath #(
   parameter int MAX_WIDTH  = blpf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = blpf_pkg::DEF_MAX_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  blpf_pkg::blpf_cmd_type    cmd,
   output blpf_pkg::blpf_status_type status,
   input  logic [7:0]                screen_width,
   input  logic [6:0]                screen_height,
   input  logic [7:0]                req_x_start,
   input  logic [7:0]                req_y_start,
   input  logic [7:0]                req_x_end,
   input  logic [7:0]                req_y_end,
   input  logic [7:0]                req_fill_byte,
   input  logic [9:0]                req_read_address,
   output logic [7:0]                rsp_read_data,
   output logic                      rsp_clipped
);
   import blpf_pkg::*;

   localparam int DEPTH = MAX_WIDTH * ((MAX_HEIGHT + 7) / 8);
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int RAW   = ((AW > 10) ? AW : 10) + 1;

   logic [7:0] mem [DEPTH];

   logic [7:0]        w_eff;
   logic [6:0]        h_eff;
   logic [14:0]       area;
   logic [7:0]        dx_in;
   logic [7:0]        dy_in;

   logic [7:0]        w_eff_ff;
   logic [6:0]        h_eff_ff;
   logic [7:0]        x_ff;
   logic [7:0]        y_ff;
   logic [7:0]        x_end_ff;
   logic [7:0]        y_end_ff;
   logic [7:0]        dx_ff;
   logic [7:0]        dy_ff;
   logic              x_neg_ff;
   logic              y_neg_ff;
   logic signed [11:0] err_ff;
   logic [7:0]        fill_ff;
   logic [RAW-1:0]    read_addr_ff;
   logic [CW-1:0]     fill_count_ff;
   logic [CW-1:0]     cnt_ff;
   logic [AW-1:0]     pix_addr_ff;
   logic [7:0]        mask_ff;
   logic [7:0]        rd_data_ff;
   logic [7:0]        rsp_read_data_ff;
   logic              rsp_clipped_ff;

   logic [13:0]       pix_addr_full;
   logic [AW-1:0]     pix_addr;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [7:0]        wr_data;
   logic              read_ok;

   logic signed [12:0] e2;
   logic signed [12:0] dx_s;
   logic signed [12:0] dy_s;
   logic signed [12:0] err_sum;
   logic               step_x;
   logic               step_y;

   assign w_eff = (screen_width > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : screen_width;
   assign h_eff = ({1'b0, screen_height} > 8'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : screen_height;
   assign area  = 15'(w_eff) * 15'(h_eff);
   assign dx_in = (req_x_end > req_x_start) ? req_x_end - req_x_start
                                            : req_x_start - req_x_end;
   assign dy_in = (req_y_end > req_y_start) ? req_y_end - req_y_start
                                            : req_y_start - req_y_end;

   assign pix_addr_full = 14'(y_ff[7:3]) * 14'(w_eff_ff) + 14'(x_ff);
   assign pix_addr      = pix_addr_full[AW-1:0];

   assign e2      = 13'(err_ff) <<< 1;
   assign dx_s    = signed'(13'(dx_ff));
   assign dy_s    = signed'(13'(dy_ff));
   assign step_x  = (e2 > -dy_s);
   assign step_y  = (e2 < dx_s);
   assign err_sum = 13'(err_ff) - (step_x ? dy_s : 13'sd0) + (step_y ? dx_s : 13'sd0);

   assign status.on_screen = (x_ff < w_eff_ff) && (y_ff < {1'b0, h_eff_ff});
   assign status.at_end    = (x_ff == x_end_ff) && (y_ff == y_end_ff);
   assign status.wipe_last = (cnt_ff == CW'(DEPTH - 1));
   assign status.fill_done = (cnt_ff == fill_count_ff);

   assign read_ok = (read_addr_ff < RAW'(DEPTH));
   assign rd_addr = cmd.pix_read ? pix_addr : read_addr_ff[AW-1:0];

   assign wr_en   = cmd.wipe_write | cmd.fill_write | cmd.pix_write;
   assign wr_addr = cmd.pix_write ? pix_addr_ff : cnt_ff[AW-1:0];

   always_comb begin
      priority if (cmd.pix_write) begin
         wr_data = rd_data_ff | mask_ff;
      end else if (cmd.fill_write) begin
         wr_data = fill_ff;
      end else begin
         wr_data = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         w_eff_ff      <= w_eff;
         h_eff_ff      <= h_eff;
         x_ff          <= req_x_start;
         y_ff          <= req_y_start;
         x_end_ff      <= req_x_end;
         y_end_ff      <= req_y_end;
         dx_ff         <= dx_in;
         dy_ff         <= dy_in;
         x_neg_ff      <= (req_x_start > req_x_end);
         y_neg_ff      <= (req_y_start > req_y_end);
         err_ff        <= signed'(12'(dx_in)) - signed'(12'(dy_in));
         fill_ff       <= req_fill_byte;
         read_addr_ff  <= RAW'(req_read_address);
         fill_count_ff <= CW'(area >> 3);
      end else if (cmd.pix_write) begin
         err_ff <= 12'(err_sum);
         if (step_x) begin
            x_ff <= x_neg_ff ? x_ff - 8'd1 : x_ff + 8'd1;
         end
         if (step_y) begin
            y_ff <= y_neg_ff ? y_ff - 8'd1 : y_ff + 8'd1;
         end
      end
      if (cmd.pix_read) begin
         pix_addr_ff <= pix_addr;
         mask_ff     <= 8'd1 << y_ff[2:0];
      end
      if (cmd.finish) begin
         rsp_read_data_ff <= (cmd.read_result && read_ok) ? rd_data_ff : 8'd0;
         rsp_clipped_ff   <= cmd.clip;
      end
   end

   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_clipped   = rsp_clipped_ff;

endmodule

// ===== rtl/bresenham_line_page_framebuffer_unit.sv =====
// Top level of the paged framebuffer line engine: screen registers and wiring.
// Depends on blpf_pkg, blpf_ctrl and blpf_datapath.
//
//  Channel    Handshake              Payload
//  request    start / busy           req_op, req_x_start .. req_read_address
//  response   rsp_valid (1 cycle)    rsp_read_data, rsp_clipped
//  registers  csr_valid / csr_ready  csr_index, csr_data
//
// After reset a wipe pass zeroes the pixel store, one byte a cycle:
// MAX_WIDTH * ceil(MAX_HEIGHT / 8) bytes (1024 by default), busy high throughout.
// Draw reads each plotted pixel's store byte, then writes it back with its bit set,
// and stops at an off-screen pixel; clear writes width * height / 8 bytes;
// read fetches one byte of the store, and a no-op only sends the response.
// The response strobe follows the last cycle; start is taken again in that cycle.
// The receiver cannot stall; register writes are taken in every cycle.
module bresenham_line_page_framebuffer_unit #(
   parameter int MAX_WIDTH  = blpf_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = blpf_pkg::DEF_MAX_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_op,
   input  logic [7:0] req_x_start,
   input  logic [7:0] req_y_start,
   input  logic [7:0] req_x_end,
   input  logic [7:0] req_y_end,
   input  logic [7:0] req_fill_byte,
   input  logic [9:0] req_read_address,
   output logic       rsp_valid,
   output logic [7:0] rsp_read_data,
   output logic       rsp_clipped,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_index,
   input  logic [7:0] csr_data
);
   import blpf_pkg::*;

   logic [7:0]      screen_width_ff;
   logic [6:0]      screen_height_ff;
   blpf_cmd_type    cmd;
   blpf_status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= SCREEN_WIDTH_RESET;
         screen_height_ff <= SCREEN_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_data;
            CSR_SCREEN_HEIGHT: screen_height_ff <= csr_data[6:0];
            default:           screen_width_ff  <= screen_width_ff;
         endcase
      end
   end

   blpf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (req_op),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   blpf_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .screen_width     (screen_width_ff),
      .screen_height    (screen_height_ff),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_fill_byte    (req_fill_byte),
      .req_read_address (req_read_address),
      .rsp_read_data    (rsp_read_data),
      .rsp_clipped      (rsp_clipped)
   );

endmodule

// ===== test/tb_bresenham_line_page_framebuffer_unit.sv =====
// Testbench for bresenham_line_page_framebuffer_unit: a directed table, then random
// phases under several screen settings, every response checked against a fixed
// reply or an in-bench model. Depends on blpf_pkg and the top level of the line engine.
`timescale 1ns / 100ps

module tb_bresenham_line_page_framebuffer_unit;
   import blpf_pkg::*;

   localparam int STORE_BYTES      = DEF_MAX_WIDTH * ((DEF_MAX_HEIGHT + 7) / 8);
   localparam int STORE_AW         = $clog2(STORE_BYTES);
   localparam int CYCLE_LIMIT      = 8_000_000;
   localparam int PHASES           = 9;
   localparam int PHASE_W          = $clog2(PHASES);
   localparam int RANDOM_PER_PHASE = 205;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [7:0] fill_byte;
      logic [9:0] read_address;
   } job_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } reply_type;

   typedef struct packed {
      job_type   job;
      logic      fixed;
      reply_type reply;
   } line_case_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [1:0] req_op = OP_NOP;
   logic [7:0] req_x_start = '0;
   logic [7:0] req_y_start = '0;
   logic [7:0] req_x_end = '0;
   logic [7:0] req_y_end = '0;
   logic [7:0] req_fill_byte = '0;
   logic [9:0] req_read_address = '0;
   logic       rsp_valid;
   logic [7:0] rsp_read_data;
   logic       rsp_clipped;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic       csr_index = CSR_SCREEN_WIDTH;
   logic [7:0] csr_data = '0;

   logic [7:0]    frame_mem [STORE_BYTES];
   logic [7:0]    scr_width;
   logic [6:0]    scr_height;
   reply_type     awaited [$];
   reply_type     due;
   line_case_type line_cases [$];
   int            mismatches = 0;
   int            replies_seen = 0;
   int unsigned   cycles = 0;
   bit            calm = 1'b0;

   logic [7:0] phase_width [PHASES]  = '{8'd1, 8'd16, 8'd255, 8'd0, 8'd40, 8'd33, 8'd128,
                                         8'd8, 8'd96};
   logic [7:0] phase_height [PHASES] = '{8'd8, 8'd16, 8'd255, 8'd24, 8'd0, 8'd13, 8'd64,
                                         8'd64, 8'd40};

   bresenham_line_page_framebuffer_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int eff_width();
      return (scr_width > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(scr_width);
   endfunction

   function automatic int eff_height();
      return (scr_height > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(scr_height);
   endfunction

   function automatic bit set_pixel(int x, int y);
      int w;
      int h;
      int a;
      w = eff_width();
      h = eff_height();
      if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
      a = (y / 8) * w + x;
      if (a < STORE_BYTES) frame_mem[STORE_AW'(a)][3'(y % 8)] = 1'b1;
      return 1'b1;
   endfunction

   function automatic logic trace_line(int x0, int y0, int x1, int y1);
      int   dx;
      int   dy;
      int   sx;
      int   sy;
      int   err;
      int   e2;
      int   x;
      int   y;
      logic clip;
      bit   running;
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      sx = (x0 > x1) ? -1 : 1;
      sy = (y0 > y1) ? -1 : 1;
      err = dx - dy;
      x = x0;
      y = y0;
      clip = 1'b0;
      running = 1'b1;
      while (running) begin
         if (!set_pixel(x, y)) begin
            clip = 1'b1;
            running = 1'b0;
         end else if (x == x1 && y == y1) begin
            running = 1'b0;
         end else begin
            e2 = 2 * err;
            if (e2 > -dy) begin
               err -= dy;
               x += sx;
            end
            if (e2 < dx) begin
               err += dx;
               y += sy;
            end
         end
      end
      return clip;
   endfunction

   function automatic reply_type render_item(job_type j);
      reply_type r;
      int        n;
      r = '0;
      case (j.op)
         OP_DRAW: begin
            r.clipped = trace_line(int'(j.x_start), int'(j.y_start),
                                   int'(j.x_end), int'(j.y_end));
         end
         OP_CLEAR: begin
            n = eff_width() * eff_height() / 8;
            if (n > STORE_BYTES) n = STORE_BYTES;
            for (int i = 0; i < n; i++) frame_mem[STORE_AW'(i)] = j.fill_byte;
         end
         OP_READ: begin
            if (j.read_address < STORE_BYTES) r.read_data = frame_mem[j.read_address];
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pick_coord(int limit);
      if (limit > 0 && $urandom_range(99) < 85) return 8'($urandom_range(limit - 1));
      return 8'($urandom_range(255));
   endfunction

   function automatic job_type random_job();
      job_type j;
      int      w;
      int      h;
      int      span;
      int      roll;
      w = eff_width();
      h = eff_height();
      span = w * ((h + 7) / 8);
      roll = $urandom_range(99);
      j.op = (roll < 45) ? OP_DRAW : (roll < 50) ? OP_CLEAR : (roll < 88) ? OP_READ : OP_NOP;
      j.x_start = pick_coord(w);
      j.y_start = pick_coord(h);
      j.x_end = pick_coord(w);
      j.y_end = pick_coord(h);
      j.fill_byte = 8'($urandom_range(255));
      j.read_address = (span > 0 && $urandom_range(99) < 85) ? 10'($urandom_range(span - 1))
                                                             : 10'($urandom_range(1023));
      return j;
   endfunction

   task automatic add_row(logic [1:0] op, logic [7:0] xs, ys, xe, ye, fill,
                          logic [9:0] addr, logic fixed, logic [7:0] rd, logic clip);
      line_case_type c;
      c.job = '{op, xs, ys, xe, ye, fill, addr};
      c.fixed = fixed;
      c.reply = '{rd, clip};
      line_cases.push_back(c);
   endtask

   // hold the item until the transfer, dropping start at random meanwhile
   task automatic issue(job_type j, logic fixed, reply_type fixed_reply);
      reply_type r;
      req_op <= j.op;
      req_x_start <= j.x_start;
      req_y_start <= j.y_start;
      req_x_end <= j.x_end;
      req_y_end <= j.y_end;
      req_fill_byte <= j.fill_byte;
      req_read_address <= j.read_address;
      start <= calm || $urandom_range(99) >= 8;
      @(posedge clock);
      while (!(start && !busy)) begin
         start <= calm || $urandom_range(99) >= 8;
         @(posedge clock);
      end
      r = render_item(j);
      awaited.push_back(fixed ? fixed_reply : r);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (awaited.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_SCREEN_WIDTH) scr_width = val;
      else scr_height = val[6:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         replies_seen++;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response %0d unexpected: read_data=%h clipped=%b",
                        replies_seen, rsp_read_data, rsp_clipped);
         end else begin
            due = awaited.pop_front();
            if (rsp_read_data !== due.read_data || rsp_clipped !== due.clipped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("response %0d: expected read_data=%h clipped=%b, got %h %b",
                           replies_seen, due.read_data, due.clipped,
                           rsp_read_data, rsp_clipped);
            end
         end
      end
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_bresenham_line_page_framebuffer_unit: errors");
      $finish;
   end

   initial begin
      for (int i = 0; i < STORE_BYTES; i++) frame_mem[STORE_AW'(i)] = '0;
      scr_width = SCREEN_WIDTH_RESET;
      scr_height = SCREEN_HEIGHT_RESET;

      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd0, 1, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd1023, 1, 8'h00, 0);
      add_row(OP_NOP,   255, 255, 255, 255, 255, 10'd1023, 1, 8'h00, 0);
      add_row(OP_DRAW,  0, 0, 0, 0, 0, 10'd0, 1, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd0, 1, 8'h01, 0);
      add_row(OP_DRAW,  127, 63, 127, 63, 0, 10'd0, 1, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd1023, 1, 8'h80, 0);
      add_row(OP_DRAW,  0, 0, 127, 63, 0, 10'd0, 0, 8'h00, 0);
      add_row(OP_DRAW,  127, 0, 0, 63, 0, 10'd0, 0, 8'h00, 0);
      add_row(OP_DRAW,  255, 255, 0, 0, 0, 10'd0, 1, 8'h00, 1);
      add_row(OP_DRAW,  0, 0, 255, 0, 0, 10'd0, 1, 8'h00, 1);
      add_row(OP_DRAW,  10, 60, 10, 255, 0, 10'd0, 1, 8'h00, 1);
      add_row(OP_DRAW,  5, 5, 200, 9, 0, 10'd0, 0, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd64, 0, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd128, 0, 8'h00, 0);
      add_row(OP_CLEAR, 0, 0, 0, 0, 8'hFF, 10'd0, 1, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd1023, 1, 8'hFF, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd512, 1, 8'hFF, 0);
      add_row(OP_DRAW,  3, 0, 7, 63, 0, 10'd0, 0, 8'h00, 0);
      add_row(OP_CLEAR, 0, 0, 0, 0, 8'hA5, 10'd0, 1, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd300, 1, 8'hA5, 0);
      add_row(OP_DRAW,  0, 255, 255, 0, 0, 10'd0, 1, 8'h00, 1);
      add_row(OP_DRAW,  100, 40, 20, 45, 0, 10'd0, 0, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd700, 0, 8'h00, 0);
      add_row(OP_CLEAR, 0, 0, 0, 0, 8'h00, 10'd0, 1, 8'h00, 0);
      add_row(OP_READ,  0, 0, 0, 0, 0, 10'd5, 1, 8'h00, 0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (line_cases[i]) issue(line_cases[i].job, line_cases[i].fixed, line_cases[i].reply);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_reg(CSR_SCREEN_WIDTH, phase_width[PHASE_W'(p)]);
         write_reg(CSR_SCREEN_HEIGHT, phase_height[PHASE_W'(p)]);
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            calm = (k >= 60 && k < 120);
            issue(random_job(), 1'b0, '0);
         end
         calm = 1'b0;
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && awaited.size() == 0)
         $display("tb_bresenham_line_page_framebuffer_unit: clean");
      else
         $display("tb_bresenham_line_page_framebuffer_unit: errors");
      $finish;
   end

endmodule
